FILE: design/sclw_pkg.sv
// ----------------------------------------------------------------------------
// sclw_pkg
// Shared constants and types for the stair climbing way counter.
// ----------------------------------------------------------------------------
package sclw_pkg;

   // Default sizing of the table and of the multi-limb numbers.
   localparam int DEF_MAX_STAIRS = 120;
   localparam int DEF_LIMB_COUNT = 4;

   // Fixed field widths.
   localparam int FIELD_W = 7;
   localparam int LIMB_W  = 30;

   // One limb holds a base 10^9 digit.
   localparam logic [LIMB_W-1:0] LIMB_BASE = 30'd1000000000;

   // Reset value of the jump length register.
   localparam logic [FIELD_W-1:0] MAX_JUMP_RESET = 7'd2;

   // Controls from the sequencer to the window sum unit.
   typedef struct packed {
      logic load_one;   // load the value one into the window sum
      logic calc_shift; // compute one limb and shift it into the tail
      logic out_shift;  // rotate one limb from the head to the tail
      logic double_en;  // add the head limb twice
      logic sub_en;     // subtract the limb read from the table
      logic carry_clr;  // first limb of a step, carry in is zero
   } win_ctrl_type;

endpackage

FILE: design/stair_climb_way_counter.sv
// ----------------------------------------------------------------------------
// stair_climb_way_counter
// Counts the ways to climb n stairs with jumps of 1 to max_jump stairs.
// ----------------------------------------------------------------------------
// A request transaction carries the stair count n (saturated to MAX_STAIRS);
// the answer leaves as LIMB_COUNT response transactions, each one base 10^9
// limb, least significant first, with rsp_last_limb set on the last. The
// count is built with a sliding window: with S(0) = 1, step i stores
// ways[i] = S and forms the next S = 2*S - ways[i-k] (S alone at step 0, and
// no subtraction while i < k), so one table read per limb replaces a sum over
// the whole window. Limbs move through a shift register and a single limb
// adder, one limb per cycle, and each step opens with a phase that primes the
// registered table read. The answer then leaves limb by limb, each limb held
// until rsp_ready takes it. One request is worked on at a time; req_ready is
// high only while the block is idle. The max_jump register (0 acts as 1) is
// written through csr_wr_en/csr_wr_data and must only change while the block
// is idle.
// ----------------------------------------------------------------------------
module stair_climb_way_counter #(
   parameter int MAX_STAIRS = sclw_pkg::DEF_MAX_STAIRS,
   parameter int LIMB_COUNT = sclw_pkg::DEF_LIMB_COUNT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [sclw_pkg::FIELD_W-1:0] req_stair_count,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [sclw_pkg::LIMB_W-1:0]  rsp_limb_value,
   output logic                         rsp_last_limb,
   input  logic                         csr_wr_en,
   input  logic [sclw_pkg::FIELD_W-1:0] csr_wr_data
);
   import sclw_pkg::*;

   // Index width covers stair numbers 0..MAX_STAIRS.
   localparam int IW     = $clog2(MAX_STAIRS + 1);
   // Limb select width and the width of a phase counter that reaches LIMB_COUNT.
   localparam int LW     = $clog2(LIMB_COUNT);
   localparam int PW     = $clog2(LIMB_COUNT + 1);
   localparam int CW     = (IW > FIELD_W) ? IW : FIELD_W;
   localparam int ADDR_W = IW + LW;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_STEP = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [FIELD_W-1:0] max_jump_ff;
   logic [FIELD_W-1:0] jump_ff, jump_in;
   logic [IW-1:0]     stairs_ff, stairs_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [PW-1:0]     phase_ff, phase_in;
   logic [LW-1:0]     out_cnt_ff, out_cnt_in;

   win_ctrl_type      win_ctrl;
   logic [LIMB_W-1:0] head_limb;
   logic [LIMB_W-1:0] tab_rd_data;
   logic              tab_wr_en;
   logic [ADDR_W-1:0] tab_wr_addr;
   logic [ADDR_W-1:0] tab_rd_addr;

   logic              req_fire;
   logic              rsp_fire;
   logic              sub_active;
   logic [CW-1:0]     back_idx;
   logic [PW-1:0]     wr_phase;
   logic              step_done;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // The subtracted entry lies k places back; before that it is absent.
   assign sub_active = CW'(idx_ff) >= CW'(jump_ff);
   assign back_idx   = CW'(idx_ff) - CW'(jump_ff);
   assign wr_phase   = phase_ff - PW'(1);
   assign step_done  = phase_ff == PW'(LIMB_COUNT);

   // Phase p reads limb p of the back entry; the registered data is used in
   // phase p+1, which also computes and stores limb p of the current entry.
   assign tab_rd_addr = {back_idx[IW-1:0], phase_ff[LW-1:0]};
   assign tab_wr_addr = {idx_ff, wr_phase[LW-1:0]};
   assign tab_wr_en   = (state_ff == ST_STEP) && (phase_ff != '0);

   always_comb begin
      state_in   = state_ff;
      jump_in    = jump_ff;
      stairs_in  = stairs_ff;
      idx_in     = idx_ff;
      phase_in   = phase_ff;
      out_cnt_in = out_cnt_ff;
      win_ctrl   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // Saturate the stair count and treat a zero jump length as one.
               if (req_stair_count > FIELD_W'(MAX_STAIRS)) begin
                  stairs_in = IW'(MAX_STAIRS);
               end else begin
                  stairs_in = IW'(req_stair_count);
               end
               jump_in           = (max_jump_ff == '0) ? FIELD_W'(1) : max_jump_ff;
               idx_in            = '0;
               phase_in          = '0;
               out_cnt_in        = '0;
               win_ctrl.load_one = 1'b1;
               state_in          = (req_stair_count == '0) ? ST_EMIT : ST_STEP;
            end
         end
         ST_STEP: begin
            if (phase_ff != '0) begin
               win_ctrl.calc_shift = 1'b1;
               win_ctrl.double_en  = idx_ff != '0;
               win_ctrl.sub_en     = sub_active;
               win_ctrl.carry_clr  = phase_ff == PW'(1);
            end
            if (step_done) begin
               phase_in = '0;
               idx_in   = idx_ff + IW'(1);
               if (idx_ff + IW'(1) == stairs_ff) begin
                  state_in = ST_EMIT;
               end
            end else begin
               phase_in = phase_ff + PW'(1);
            end
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               win_ctrl.out_shift = 1'b1;
               out_cnt_in         = out_cnt_ff + LW'(1);
               if (out_cnt_ff == LW'(LIMB_COUNT - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         max_jump_ff <= MAX_JUMP_RESET;
         phase_ff    <= '0;
         out_cnt_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         out_cnt_ff <= out_cnt_in;
         if (csr_wr_en) begin
            max_jump_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      jump_ff   <= jump_in;
      stairs_ff <= stairs_in;
      idx_ff    <= idx_in;
   end

   assign req_ready      = state_ff == ST_IDLE;
   assign rsp_valid      = state_ff == ST_EMIT;
   assign rsp_limb_value = head_limb;
   assign rsp_last_limb  = out_cnt_ff == LW'(LIMB_COUNT - 1);

   sclw_ways_ram #(
      .ADDR_W (ADDR_W)
   ) u_ways_ram (
      .clock   (clock),
      .wr_en   (tab_wr_en),
      .wr_addr (tab_wr_addr),
      .wr_data (head_limb),
      .rd_addr (tab_rd_addr),
      .rd_data (tab_rd_data)
   );

   sclw_window_unit #(
      .LIMB_COUNT (LIMB_COUNT)
   ) u_window_unit (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (win_ctrl),
      .sub_limb  (tab_rd_data),
      .head_limb (head_limb)
   );

endmodule

FILE: design/sclw_ways_ram.sv
// ----------------------------------------------------------------------------
// sclw_ways_ram
// Table of earlier counts, one limb per word, one write and one read port.
// ----------------------------------------------------------------------------
module sclw_ways_ram #(
   parameter int ADDR_W = 9
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [sclw_pkg::LIMB_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [sclw_pkg::LIMB_W-1:0] rd_data
);
   import sclw_pkg::*;

   localparam int DEPTH = 1 << ADDR_W;

   logic [LIMB_W-1:0] mem [DEPTH];
   logic [LIMB_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/sclw_window_unit.sv
// ----------------------------------------------------------------------------
// sclw_window_unit
// Window sum held as a limb-wide shift register with a serial limb adder.
// ----------------------------------------------------------------------------
module sclw_window_unit #(
   parameter int LIMB_COUNT = sclw_pkg::DEF_LIMB_COUNT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sclw_pkg::win_ctrl_type      ctrl,
   input  logic [sclw_pkg::LIMB_W-1:0] sub_limb,
   output logic [sclw_pkg::LIMB_W-1:0] head_limb
);
   import sclw_pkg::*;

   logic [LIMB_W-1:0] limbs_ff [LIMB_COUNT];
   logic [LIMB_W-1:0] limbs_in [LIMB_COUNT];
   logic signed [1:0] carry_ff;
   logic signed [1:0] carry_in;
   logic signed [1:0] carry_eff;
   logic [LIMB_W-1:0] dbl_limb;
   logic [LIMB_W-1:0] sub_eff;
   logic signed [32:0] raw_sum;
   logic [LIMB_W-1:0] new_limb;

   assign head_limb = limbs_ff[0];

   // One limb of head + head - sub + carry, carry in {-1, 0, +1}.
   always_comb begin
      carry_eff = ctrl.carry_clr ? 2'sd0 : carry_ff;
      dbl_limb  = ctrl.double_en ? limbs_ff[0] : '0;
      sub_eff   = ctrl.sub_en ? sub_limb : '0;
      raw_sum   = $signed({3'b000, limbs_ff[0]}) + $signed({3'b000, dbl_limb})
                - $signed({3'b000, sub_eff}) + $signed({{31{carry_eff[1]}}, carry_eff});
      if (raw_sum >= $signed({3'b000, LIMB_BASE})) begin
         new_limb = LIMB_W'(raw_sum - $signed({3'b000, LIMB_BASE}));
         carry_in = 2'sd1;
      end else if (raw_sum < 33'sd0) begin
         new_limb = LIMB_W'(raw_sum + $signed({3'b000, LIMB_BASE}));
         carry_in = -2'sd1;
      end else begin
         new_limb = LIMB_W'(raw_sum);
         carry_in = 2'sd0;
      end
   end

   always_comb begin
      for (int j = 0; j < LIMB_COUNT; j++) begin
         limbs_in[j] = limbs_ff[j];
      end
      if (ctrl.load_one) begin
         for (int j = 0; j < LIMB_COUNT; j++) begin
            limbs_in[j] = '0;
         end
         limbs_in[0] = LIMB_W'(1);
      end else if (ctrl.calc_shift || ctrl.out_shift) begin
         for (int j = 0; j < LIMB_COUNT - 1; j++) begin
            limbs_in[j] = limbs_ff[j+1];
         end
         limbs_in[LIMB_COUNT-1] = ctrl.calc_shift ? new_limb : limbs_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < LIMB_COUNT; j++) begin
         limbs_ff[j] <= limbs_in[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= 2'sd0;
      end else if (ctrl.calc_shift) begin
         carry_ff <= carry_in;
      end
   end

endmodule

FILE: design/sclw_checker.sv
// ----------------------------------------------------------------------------
// sclw_checker
// Port-level checks for the stair climbing way counter, bound to the top.
// ----------------------------------------------------------------------------
module sclw_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [sclw_pkg::LIMB_W-1:0]  rsp_limb_value,
   input logic                         rsp_last_limb
);
   import sclw_pkg::*;

   // A stalled response holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_limb_value)
                                  && $stable(rsp_last_limb))
      else $error("stalled response changed");

   // No request is taken while an answer is being handed out.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready during response");

   // The last limb ends the answer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_limb |=> !rsp_valid && req_ready)
      else $error("response continued after last limb");

   // A taken request closes the input until its answer is out.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

endmodule

bind stair_climb_way_counter sclw_checker u_sclw_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_limb_value  (rsp_limb_value),
   .rsp_last_limb   (rsp_last_limb)
);

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stair climbing way counter.
// ----------------------------------------------------------------------------
// A table of hand-picked requests runs first. Where the answer is obvious
// (tiny stair counts, single-stair jumps, short Fibonacci and tribonacci
// values) the table carries it. Every other request is checked against a
// limb-accurate count built inside the bench. A long random run follows in
// phases, each with its own max_jump setting. Idle cycles on the request and
// response sides are enabled per phase at random, never in the final phase.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sclw_pkg::*;

   localparam int STAIR_LIMIT = DEF_MAX_STAIRS;
   localparam int LIMBS       = DEF_LIMB_COUNT;
   localparam int PHASE_ITEMS = 60;
   localparam int PHASES      = 7;

   // All limbs of one count. Index 0 is the least significant base 10^9 digit.
   typedef logic [LIMBS-1:0][LIMB_W-1:0] limb_set_type;

   // One response transaction, in the form the bench expects to see it.
   typedef struct packed {
      logic [LIMB_W-1:0] limb;
      logic              last;
   } limb_rsp_type;

   // One row of the directed table. When known is set, answer is the whole
   // count and the upper limbs are zero. Otherwise the count is computed.
   typedef struct packed {
      logic [FIELD_W-1:0] jump;
      logic [FIELD_W-1:0] stairs;
      logic               known;
      logic [LIMB_W-1:0]  answer;
   } climb_row_type;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_ready;
   logic [FIELD_W-1:0]  req_stair_count = '0;
   logic                rsp_valid;
   logic                rsp_ready       = 1'b0;
   logic [LIMB_W-1:0]   rsp_limb_value;
   logic                rsp_last_limb;
   logic                csr_wr_en       = 1'b0;
   logic [FIELD_W-1:0]  csr_wr_data     = '0;

   // Limbs still owed by the block, oldest first.
   limb_rsp_type        owed_limbs[$];
   int                  fault_count     = 0;
   // The max_jump value that the block currently holds.
   logic [FIELD_W-1:0]  jump_setting    = MAX_JUMP_RESET;
   // Turns the random idle bursts on both sides on and off.
   bit                  idle_enabled    = 1'b1;
   int                  stall_left      = 0;

   // Hand-picked cases. The first rows run with the reset value of max_jump.
   // A zero jump must act like a jump of one. Counts above the table size
   // saturate to the largest stair count.
   climb_row_type directed_rows [0:21] = '{
      '{7'd2,   7'd0,   1'b1, 30'd1},
      '{7'd2,   7'd1,   1'b1, 30'd1},
      '{7'd2,   7'd2,   1'b1, 30'd2},
      '{7'd2,   7'd3,   1'b1, 30'd3},
      '{7'd2,   7'd10,  1'b1, 30'd89},
      '{7'd2,   7'd120, 1'b0, 30'd0},
      '{7'd2,   7'd127, 1'b0, 30'd0},
      '{7'd2,   7'd121, 1'b0, 30'd0},
      '{7'd0,   7'd5,   1'b1, 30'd1},
      '{7'd0,   7'd127, 1'b1, 30'd1},
      '{7'd1,   7'd120, 1'b1, 30'd1},
      '{7'd1,   7'd0,   1'b1, 30'd1},
      '{7'd3,   7'd4,   1'b1, 30'd7},
      '{7'd3,   7'd120, 1'b0, 30'd0},
      '{7'd120, 7'd2,   1'b1, 30'd2},
      '{7'd120, 7'd3,   1'b1, 30'd4},
      '{7'd120, 7'd120, 1'b0, 30'd0},
      '{7'd127, 7'd127, 1'b0, 30'd0},
      '{7'd127, 7'd64,  1'b0, 30'd0},
      '{7'd119, 7'd120, 1'b0, 30'd0},
      '{7'd64,  7'd100, 1'b0, 30'd0},
      '{7'd85,  7'd42,  1'b0, 30'd0}
   };

   stair_climb_way_counter DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_stair_count (req_stair_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_limb_value  (rsp_limb_value),
      .rsp_last_limb   (rsp_last_limb),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #1 clock = ~clock;

   // Computes the number of ways to climb the given stairs from scratch. Each
   // table entry is the plain sum of the previous min(k, i) entries. The block
   // uses a sliding window, so the two methods are computed independently.
   // Limbs are added one at a time with a decimal carry between them.
   function automatic limb_set_type count_ways(input logic [FIELD_W-1:0] stairs,
                                               input logic [FIELD_W-1:0] jump);
      limb_set_type ways [0:STAIR_LIMIT];
      limb_set_type acc;
      int unsigned  n;
      int unsigned  k;
      int unsigned  lo;
      int unsigned  sum;
      int unsigned  carry;
      n = (stairs > STAIR_LIMIT) ? STAIR_LIMIT : stairs;
      k = (jump == 0) ? 1 : jump;
      ways[0]    = '0;
      ways[0][0] = LIMB_W'(1);
      ways[1]    = ways[0];
      for (int unsigned i = 2; i <= n; i++) begin
         lo  = (i > k) ? i - k : 0;
         acc = '0;
         for (int unsigned m = lo; m < i; m++) begin
            carry = 0;
            for (int j = 0; j < LIMBS; j++) begin
               sum    = acc[j] + ways[m][j] + carry;
               carry  = (sum >= LIMB_BASE) ? 1 : 0;
               acc[j] = (carry != 0) ? LIMB_W'(sum - LIMB_BASE) : LIMB_W'(sum);
            end
         end
         ways[i] = acc;
      end
      return ways[n];
   endfunction

   // Sends one request transaction and records the limbs that it must produce.
   // The caller returns in the time step of the accepting edge. That way the
   // next request can keep valid high without a dead cycle.
   task automatic send_request(input logic [FIELD_W-1:0] stairs,
                               input limb_set_type answer);
      int           gap;
      limb_rsp_type due;
      gap = (idle_enabled && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_stair_count <= stairs;
      do @(posedge clock); while (!req_ready);
      for (int j = 0; j < LIMBS; j++) begin
         due.limb   = answer[j];
         due.last   = (j == LIMBS - 1);
         owed_limbs = {owed_limbs, due};
      end
   endtask

   // Stops sending and waits until every owed limb has arrived and the block
   // is ready to take a new request.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (owed_limbs.size() != 0 || !req_ready);
   endtask

   // max_jump may only change while the block is idle.
   task automatic set_max_jump(input logic [FIELD_W-1:0] jump);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= jump;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      jump_setting  = jump;
   endtask

   // Response side. Each limb handed over is checked against the oldest owed
   // limb. The same block also drives rsp_ready low in short random bursts.
   always @(posedge clock) begin : rsp_side
      limb_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_limbs.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("%0t: response with none owed: limb %0d last %0b",
                        $realtime, rsp_limb_value, rsp_last_limb);
         end else begin
            want = owed_limbs.pop_front();
            if (rsp_limb_value !== want.limb || rsp_last_limb !== want.last) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("%0t: limb expected %0d last %0b, got limb %0d last %0b",
                           $realtime, want.limb, want.last, rsp_limb_value, rsp_last_limb);
            end
         end
      end
      if (stall_left > 0)
         stall_left--;
      else if (idle_enabled && $urandom_range(0, 5) == 0)
         stall_left = $urandom_range(1, 3);
      rsp_ready <= (stall_left == 0);
   end

   // Main sequence: reset, the directed table, then the random phases.
   initial begin : stimulus
      logic [FIELD_W-1:0] stairs;
      logic [FIELD_W-1:0] jump;
      limb_set_type       answer;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. max_jump is only rewritten when a row needs a new value.
      foreach (directed_rows[r]) begin
         if (directed_rows[r].jump != jump_setting)
            set_max_jump(directed_rows[r].jump);
         if (directed_rows[r].known) begin
            answer    = '0;
            answer[0] = directed_rows[r].answer;
         end else begin
            answer = count_ways(directed_rows[r].stairs, jump_setting);
         end
         send_request(directed_rows[r].stairs, answer);
      end

      // Random part. Each phase gets its own jump length, and the extremes have
      // phases of their own. Idling is random per phase and is off in the last.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: jump = FIELD_W'($urandom_range(2, 6));
            1: jump = '0;
            2: jump = '1;
            3: jump = FIELD_W'($urandom_range(1, 127));
            4: jump = 7'd1;
            5: jump = FIELD_W'($urandom_range(100, 127));
            default: jump = FIELD_W'($urandom_range(2, 40));
         endcase
         set_max_jump(jump);
         idle_enabled = (phase < PHASES - 1) && ($urandom_range(0, 3) != 0);
         for (int item = 0; item < PHASE_ITEMS; item++) begin
            // Now and then the sender holds off until the block has drained.
            if ($urandom_range(0, 49) == 0)
               wait_idle();
            case ($urandom_range(0, 9))
               0:       stairs = FIELD_W'($urandom_range(0, 3));
               1:       stairs = FIELD_W'($urandom_range(115, 127));
               default: stairs = FIELD_W'($urandom_range(0, 127));
            endcase
            send_request(stairs, count_ways(stairs, jump_setting));
         end
      end

      // Wait for the last limbs to arrive. A short tail then catches any
      // response transaction that the block sends without one being owed.
      wait_idle();
      repeat (16) @(posedge clock);
      if (fault_count == 0 && owed_limbs.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Guard against a hung handshake. This is far beyond the slowest correct run.
   initial begin : watchdog
      #3000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: sim.f
design/sclw_pkg.sv
design/sclw_ways_ram.sv
design/sclw_window_unit.sv
design/stair_climb_way_counter.sv
design/sclw_checker.sv
bench/tb_top.sv
